// ===== hw/rtl/spfa_pkg.sv =====
// ----------------------------------------------------------------------------
// spfa_pkg
// Shared constants and types for the swap pool frame allocator.
// ----------------------------------------------------------------------------
package spfa_pkg;

  localparam int unsigned POOL_SIZE         = 16;
  localparam int unsigned PAGE_BYTES        = 4096;
  localparam int unsigned PAGES_PER_PROCESS = 32;

  localparam int unsigned IDX_W      = $clog2(POOL_SIZE);
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned SLOT_W     = $clog2(PAGES_PER_PROCESS);

  // fixed field widths of the channels
  localparam int unsigned ASID_W      = 4;
  localparam int unsigned EXC_W       = 5;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned FRAME_IDX_W = 4;
  localparam int unsigned PAGE_FLD_W  = 5;

  // page number lives in entry-high bits 29..12
  localparam int unsigned VPN_LSB = 12;
  localparam int unsigned VPN_W   = 18;

  localparam logic [EXC_W-1:0]  EXC_MODIFICATION = EXC_W'(1);
  localparam logic [VPN_W-1:0]  STACK_PAGE_MARK  = 18'h3FFFF;
  localparam logic [WORD_W-1:0] ENTRY_VALID      = 32'h0000_0200;
  localparam logic [WORD_W-1:0] ENTRY_DIRTY      = 32'h0000_0400;
  localparam logic [WORD_W-1:0] ENTRY_FLAGS      = ENTRY_VALID | ENTRY_DIRTY;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [ASID_W-1:0]      asid_t;
  typedef logic [WORD_W-1:0]      word_t;
  typedef logic [FRAME_IDX_W-1:0] frame_idx_t;
  typedef logic [PAGE_FLD_W-1:0]  page_fld_t;

  localparam slot_t STACK_SLOT = slot_t'(PAGES_PER_PROCESS - 1);

  // classified fault handed from front to back
  typedef struct packed {
    logic  term;
    asid_t asid;
    slot_t slot;
  } cmd_t;

  typedef struct packed {
    logic       terminate;
    frame_idx_t frame_index;
    word_t      frame_pa;
    logic       evict_valid;
    asid_t      evict_asid;
    page_fld_t  evict_page;
    page_fld_t  read_page;
    word_t      new_entry_lo;
  } result_t;

endpackage

// ===== hw/rtl/spfa_fault_if.sv =====
// ----------------------------------------------------------------------------
// spfa_fault_if
// Page fault channel: valid/ready handshake with the fault word.
// ----------------------------------------------------------------------------
interface spfa_fault_if;
  logic                          valid;
  logic                          ready;
  logic [spfa_pkg::ASID_W-1:0]   asid;
  logic [spfa_pkg::WORD_W-1:0]   tlb_hi;
  logic [spfa_pkg::EXC_W-1:0]    exc_code;

  modport source (output valid, asid, tlb_hi, exc_code, input ready);
  modport sink   (input valid, asid, tlb_hi, exc_code, output ready);
endinterface

// ===== hw/rtl/spfa_result_if.sv =====
// ----------------------------------------------------------------------------
// spfa_result_if
// Allocation result channel: valid/ready handshake with the result word.
// ----------------------------------------------------------------------------
interface spfa_result_if;
  logic                             valid;
  logic                             ready;
  logic                             terminate;
  logic [spfa_pkg::FRAME_IDX_W-1:0] frame_index;
  logic [spfa_pkg::WORD_W-1:0]      frame_pa;
  logic                             evict_valid;
  logic [spfa_pkg::ASID_W-1:0]      evict_asid;
  logic [spfa_pkg::PAGE_FLD_W-1:0]  evict_page;
  logic [spfa_pkg::PAGE_FLD_W-1:0]  read_page;
  logic [spfa_pkg::WORD_W-1:0]      new_entry_lo;

  modport source (output valid, terminate, frame_index, frame_pa, evict_valid,
                  evict_asid, evict_page, read_page, new_entry_lo, input ready);
  modport sink   (input valid, terminate, frame_index, frame_pa, evict_valid,
                  evict_asid, evict_page, read_page, new_entry_lo, output ready);
endinterface

// ===== hw/rtl/spfa_front.sv =====
// ----------------------------------------------------------------------------
// spfa_front
// Accepts fault words, classifies them and maps the page number to a slot.
// ----------------------------------------------------------------------------
module spfa_front (
  spfa_fault_if.sink       fault_i,
  input  logic             full_i,
  output logic             push_o,
  output spfa_pkg::cmd_t   cmd_o
);

  logic [spfa_pkg::VPN_W-1:0] pageno;

  assign pageno = fault_i.tlb_hi[spfa_pkg::VPN_LSB +: spfa_pkg::VPN_W];

  assign fault_i.ready = !full_i;
  assign push_o        = fault_i.valid && !full_i;

  always_comb begin
    cmd_o.term = (fault_i.exc_code == spfa_pkg::EXC_MODIFICATION);
    cmd_o.asid = fault_i.asid;
    // stack page goes to the last slot, others wrap (slot count is a power of two)
    if (pageno == spfa_pkg::STACK_PAGE_MARK) begin
      cmd_o.slot = spfa_pkg::STACK_SLOT;
    end else begin
      cmd_o.slot = pageno[spfa_pkg::SLOT_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/spfa_queue.sv =====
// ----------------------------------------------------------------------------
// spfa_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module spfa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  spfa_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output spfa_pkg::cmd_t head_o
);

  localparam logic [spfa_pkg::QPTR_W-1:0] LastPtr = spfa_pkg::QPTR_W'(spfa_pkg::QUEUE_DEPTH - 1);

  spfa_pkg::cmd_t                entry_q [spfa_pkg::QUEUE_DEPTH];
  logic [spfa_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [spfa_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [spfa_pkg::QCNT_W-1:0]   count_q, count_d;
  logic                          do_push, do_pop;

  assign full_o  = (count_q == spfa_pkg::QCNT_W'(spfa_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + spfa_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + spfa_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + spfa_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - spfa_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== hw/rtl/spfa_back.sv =====
// ----------------------------------------------------------------------------
// spfa_back
// Picks a pool frame per non-terminate command, updates the pool and registers the result.
// ----------------------------------------------------------------------------
module spfa_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  spfa_pkg::word_t       cfg_wdata_i,
  input  logic                  empty_i,
  input  spfa_pkg::cmd_t        head_i,
  output logic                  pop_o,
  spfa_result_if.source         result_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PICK,
    ST_EMIT
  } state_e;

  localparam spfa_pkg::idx_t LastIdx = spfa_pkg::IDX_W'(spfa_pkg::POOL_SIZE - 1);

  state_e                state_q;
  spfa_pkg::cmd_t        cmd_q;
  spfa_pkg::idx_t        idx_q;
  spfa_pkg::idx_t        victim_q;
  spfa_pkg::word_t       frame_base_q;
  logic                  out_valid_q;
  spfa_pkg::result_t     res_q, res_d;

  spfa_pkg::asid_t       owner_q [spfa_pkg::POOL_SIZE];
  spfa_pkg::slot_t       page_q  [spfa_pkg::POOL_SIZE];

  logic                  any_free;
  spfa_pkg::idx_t        first_free;
  spfa_pkg::idx_t        victim_next;
  spfa_pkg::asid_t       owner_sel;
  spfa_pkg::slot_t       page_sel;
  logic                  evict;
  spfa_pkg::word_t       addr;
  logic                  out_free;
  logic                  pool_we;

  // lowest free entry
  always_comb begin
    any_free   = 1'b0;
    first_free = '0;
    for (int i = spfa_pkg::POOL_SIZE - 1; i >= 0; i--) begin
      if (owner_q[i] == '0) begin
        any_free   = 1'b1;
        first_free = spfa_pkg::IDX_W'(i);
      end
    end
  end

  assign victim_next = (victim_q == LastIdx) ? '0 : victim_q + spfa_pkg::IDX_W'(1);
  assign owner_sel   = owner_q[idx_q];
  assign page_sel    = page_q[idx_q];
  assign evict       = (owner_sel != '0);
  assign addr        = frame_base_q + (spfa_pkg::WORD_W'(idx_q) << spfa_pkg::PAGE_SHIFT);
  assign out_free    = !out_valid_q || result_o.ready;
  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign pool_we     = (state_q == ST_EMIT) && out_free && !cmd_q.term;

  always_comb begin
    res_d = '0;
    if (cmd_q.term) begin
      res_d.terminate = 1'b1;
    end else begin
      res_d.frame_index  = spfa_pkg::FRAME_IDX_W'(idx_q);
      res_d.frame_pa     = addr;
      res_d.evict_valid  = evict;
      res_d.evict_asid   = owner_sel;
      res_d.evict_page   = evict ? spfa_pkg::PAGE_FLD_W'(page_sel) : '0;
      res_d.read_page    = spfa_pkg::PAGE_FLD_W'(cmd_q.slot);
      res_d.new_entry_lo = addr | spfa_pkg::ENTRY_FLAGS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      idx_q       <= '0;
      victim_q    <= LastIdx;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if ((state_q == ST_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            cmd_q   <= head_i;
            state_q <= head_i.term ? ST_EMIT : ST_PICK;
          end
        end
        ST_PICK: begin
          if (any_free) begin
            idx_q <= first_free;
          end else begin
            idx_q    <= victim_next;
            victim_q <= victim_next;
          end
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
            res_q   <= res_d;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q <= '0;
    end else if (cfg_we_i) begin
      frame_base_q <= cfg_wdata_i;
    end
  end

  // owner 0 marks a free frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < spfa_pkg::POOL_SIZE; i++) begin
        owner_q[i] <= '0;
      end
    end else if (pool_we) begin
      owner_q[idx_q] <= cmd_q.asid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pool_we) begin
      page_q[idx_q] <= cmd_q.slot;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.terminate    = res_q.terminate;
  assign result_o.frame_index  = res_q.frame_index;
  assign result_o.frame_pa     = res_q.frame_pa;
  assign result_o.evict_valid  = res_q.evict_valid;
  assign result_o.evict_asid   = res_q.evict_asid;
  assign result_o.evict_page   = res_q.evict_page;
  assign result_o.read_page    = res_q.read_page;
  assign result_o.new_entry_lo = res_q.new_entry_lo;

endmodule

// ===== hw/rtl/swap_pool_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// swap_pool_frame_allocator
// Page frame allocator: lowest free frame, else round-robin victim.
// ----------------------------------------------------------------------------
// channel     dir  handshake           word
// fault_i     in   valid/ready         asid, tlb_hi, exc_code
// result_o    out  valid/ready         terminate, frame and eviction fields
// cfg         in   cfg_we_i            frame_base (cfg_wdata_i)
//
// each fault runs pop, frame pick, result/pool write in the back unit; a
// terminate skips the pick. one fault at a time since each pick reads the
// pool that the previous one wrote. a 2-word queue lets faults be accepted
// while the back unit works. the result register stalls the back unit only
// while a finished word is not taken. reset frees every frame at once.
// ----------------------------------------------------------------------------
module swap_pool_frame_allocator (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  spfa_pkg::word_t  cfg_wdata_i,
  spfa_fault_if.sink       fault_i,
  spfa_result_if.source    result_o
);

  logic           push;
  logic           full;
  logic           pop;
  logic           empty;
  spfa_pkg::cmd_t cmd;
  spfa_pkg::cmd_t head;

  spfa_front u_front (
    .fault_i (fault_i),
    .full_i  (full),
    .push_o  (push),
    .cmd_o   (cmd)
  );

  spfa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  spfa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .result_o    (result_o)
  );

endmodule

// ===== hw/rtl/spfa_checker.sv =====
// ----------------------------------------------------------------------------
// spfa_checker
// Port-level checks on the result channel of the frame allocator.
// ----------------------------------------------------------------------------
module spfa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic                        res_terminate_i,
  input spfa_pkg::frame_idx_t        res_frame_index_i,
  input spfa_pkg::word_t             res_frame_pa_i,
  input logic                        res_evict_valid_i,
  input spfa_pkg::asid_t             res_evict_asid_i,
  input spfa_pkg::word_t             res_new_entry_lo_i
);

  // a result word stays offered until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result word dropped while stalled");

  // terminate words carry no frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_terminate_i |->
      res_frame_index_i == '0 && res_frame_pa_i == '0 &&
      res_evict_valid_i == 1'b0 && res_new_entry_lo_i == '0)
    else $error("terminate word with frame fields set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_terminate_i |->
      res_new_entry_lo_i == (res_frame_pa_i | spfa_pkg::ENTRY_FLAGS))
    else $error("entry-low word does not match frame address");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_evict_valid_i == (res_evict_asid_i != '0))
    else $error("eviction flag disagrees with evicted owner");

endmodule

bind swap_pool_frame_allocator spfa_checker u_spfa_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .res_valid_i        (result_o.valid),
  .res_ready_i        (result_o.ready),
  .res_terminate_i    (result_o.terminate),
  .res_frame_index_i  (result_o.frame_index),
  .res_frame_pa_i     (result_o.frame_pa),
  .res_evict_valid_i  (result_o.evict_valid),
  .res_evict_asid_i   (result_o.evict_asid),
  .res_new_entry_lo_i (result_o.new_entry_lo)
);
